// ----- rtl/npq_pkg.sv -----
// ----------------------------------------------------------------------------
// npq_pkg : nearest palette colour quantizer package
// Sizes, register indexes, sequencer states and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package npq_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
	localparam int CH_W            = 8;
	localparam int IDX_W           = 8;
	localparam int SQ_W            = 2 * CH_W;
	localparam int DIST_W          = SQ_W + 2;
	localparam int REG_W           = 9;
	localparam int CFG_AW          = 2;

	localparam logic [REG_W-1:0] ENTRIES_RESET = 9'd256;
	localparam logic [CH_W-1:0]  CUTOFF_RESET  = 8'd128;

	typedef enum logic [CFG_AW-1:0] {
		REG_ENTRIES_IN_USE    = 2'd0,
		REG_TRANSPARENT_INDEX = 2'd1,
		REG_ALPHA_CUTOFF      = 2'd2
	} npq_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} npq_state_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} npq_rgb_t;

	// tag that travels with each palette read through the search pipeline
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [PAL_AW-1:0] idx;
	} npq_tag_t;

	typedef struct packed {
		logic              done;
		logic [PAL_AW-1:0] idx;
	} npq_best_t;

endpackage

`default_nettype wire

// ----- rtl/npq_pix_if.sv -----
// ----------------------------------------------------------------------------
// npq_pix_if : input channel
// Carries palette load words and pixel words with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface npq_pix_if;
	import npq_pkg::*;

	logic            valid;
	logic            ready;
	logic            mode;
	logic [7:0]      entry_index;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] alpha;

	modport source (output valid, mode, entry_index, red, green, blue, alpha, input ready);
	modport sink   (input valid, mode, entry_index, red, green, blue, alpha, output ready);
endinterface

`default_nettype wire

// ----- rtl/npq_idx_if.sv -----
// ----------------------------------------------------------------------------
// npq_idx_if : result channel
// Carries the chosen colour index with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface npq_idx_if;
	import npq_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] color_index;

	modport source (output valid, color_index, input ready);
	modport sink   (input valid, color_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/npq_palette_ram.sv -----
// ----------------------------------------------------------------------------
// npq_palette_ram : palette store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_palette_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/npq_search.sv -----
// ----------------------------------------------------------------------------
// npq_search : distance pipeline and best-match tracker
// Squares, sums and compares one palette entry per cycle against the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_search (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire npq_pkg::npq_tag_t tag_s1,
	input  wire npq_pkg::npq_rgb_t entry_s1,
	input  wire npq_pkg::npq_rgb_t pixel,
	output npq_pkg::npq_best_t     best
);
	import npq_pkg::*;

	logic [CH_W-1:0]   dr, dg, db;
	logic [SQ_W-1:0]   sqr_s2, sqg_s2, sqb_s2;
	npq_tag_t          tag_s2, tag_s3;
	logic [DIST_W-1:0] dist_s3;
	logic [DIST_W-1:0] best_dist_q;
	logic [PAL_AW-1:0] best_idx_q;
	logic              done_q;
	logic              take;

	always_comb begin
		dr = (entry_s1.red   > pixel.red)   ? entry_s1.red   - pixel.red
		                                    : pixel.red   - entry_s1.red;
		dg = (entry_s1.green > pixel.green) ? entry_s1.green - pixel.green
		                                    : pixel.green - entry_s1.green;
		db = (entry_s1.blue  > pixel.blue)  ? entry_s1.blue  - pixel.blue
		                                    : pixel.blue  - entry_s1.blue;
	end

	always_ff @(posedge clk) begin
		sqr_s2  <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s2  <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s2  <= SQ_W'(db) * SQ_W'(db);
		dist_s3 <= DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			done_q <= tag_s3.valid && tag_s3.last;
		end
	end

	// strict less-than keeps the lowest index on a tie
	assign take = tag_s3.valid && (tag_s3.first || (dist_s3 < best_dist_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= dist_s3;
			best_idx_q  <= tag_s3.idx;
		end
	end

	assign best.done = done_q;
	assign best.idx  = best_idx_q;

endmodule

`default_nettype wire

// ----- rtl/nearest_palette_color_quantizer.sv -----
// Palette load word: accepted while idle, written to the palette RAM, no result.
// Transparent pixel or zero entries in use: straight to ST_EMIT, then the result word is registered.
// Opaque pixel: one palette RAM read per cycle in ST_SCAN over the entries searched, then
// ST_DRAIN and ST_EMIT; next word taken in the cycle after the result leaves the sequencer.
// Reset clears control and sets the config registers to defaults; palette undefined until loaded.
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer : nearest palette colour quantizer
// Maps opaque RGBA pixels to the palette index with the least squared RGB distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_quantizer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	npq_pix_if.sink                          in,
	npq_idx_if.source                        out,
	input  wire logic                        cfg_we,
	input  wire logic [npq_pkg::CFG_AW-1:0]  cfg_index,
	input  wire logic [npq_pkg::REG_W-1:0]   cfg_data
);
	import npq_pkg::*;

	npq_state_t        state_q, state_d;
	logic [REG_W-1:0]  entries_q;
	logic [IDX_W-1:0]  transp_q;
	logic [CH_W-1:0]   cutoff_q;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [CNT_W-1:0]  addr_q;
	npq_rgb_t          pixel_q;
	logic [IDX_W-1:0]  result_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_valid_q;
	logic              accept, load, opaque, emit_fire, out_free;
	npq_tag_t          rd_tag, tag_s1;
	npq_rgb_t          entry_s1, wr_entry;
	npq_best_t         best;
	logic              wr_en;

	assign accept   = in.valid && in.ready;
	assign load     = accept && !in.mode;
	assign opaque   = in.alpha > cutoff_q;
	assign out_free = !out_valid_q || out.ready;
	assign used_d   = (entries_q > REG_W'(PALETTE_ENTRIES)) ? CNT_W'(PALETTE_ENTRIES)
	                                                        : CNT_W'(entries_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
			transp_q  <= '0;
			cutoff_q  <= CUTOFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRIES_IN_USE:    entries_q <= cfg_data;
				REG_TRANSPARENT_INDEX: transp_q  <= cfg_data[IDX_W-1:0];
				REG_ALPHA_CUTOFF:      cutoff_q  <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		in.ready  = 1'b0;
		emit_fire = 1'b0;
		rd_tag    = '0;
		case (state_q)
			ST_IDLE: begin
				in.ready = 1'b1;
				if (accept && in.mode) begin
					state_d = (opaque && (used_d != '0)) ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				rd_tag.valid = 1'b1;
				rd_tag.first = (addr_q == '0);
				rd_tag.last  = (addr_q == used_q - 1'b1);
				rd_tag.idx   = addr_q[PAL_AW-1:0];
				if (rd_tag.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (best.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tag_s1      <= '0;
		end else begin
			state_q <= state_d;
			tag_s1  <= rd_tag;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in.mode) begin
			pixel_q.red   <= in.red;
			pixel_q.green <= in.green;
			pixel_q.blue  <= in.blue;
			used_q        <= used_d;
			addr_q        <= '0;
			result_q      <= opaque ? '0 : transp_q;
		end else if (state_q == ST_SCAN) begin
			addr_q <= addr_q + 1'b1;
		end
		if (state_q == ST_DRAIN && best.done) begin
			result_q <= IDX_W'(best.idx);
		end
		if (emit_fire) begin
			out_idx_q <= result_q;
		end
	end

	// an 8-bit entry index always lies within the palette, so every load word is written
	assign wr_en          = load && ({1'b0, in.entry_index} < 9'(PALETTE_ENTRIES));
	assign wr_entry.red   = in.red;
	assign wr_entry.green = in.green;
	assign wr_entry.blue  = in.blue;

	npq_palette_ram #(
		.DEPTH (PALETTE_ENTRIES),
		.WIDTH ($bits(npq_rgb_t))
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (in.entry_index[PAL_AW-1:0]),
		.wdata (wr_entry),
		.raddr (addr_q[PAL_AW-1:0]),
		.rdata (entry_s1)
	);

	npq_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.entry_s1 (entry_s1),
		.pixel    (pixel_q),
		.best     (best)
	);

	assign out.valid       = out_valid_q;
	assign out.color_index = out_idx_q;

endmodule

`default_nettype wire

// ----- rtl/npq_checker.sv -----
// ----------------------------------------------------------------------------
// npq_checker : port-level checks
// Watches the quantizer's channels and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module npq_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_mode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_color_index
);

	// held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_color_index))
		else $error("result word dropped or changed while stalled");

	// a pixel word keeps the block busy: no new word is taken straight after it
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode |=> !in_ready)
		else $error("new word taken straight after a pixel");

	// a load word never raises a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_mode && !out_valid |=> !out_valid)
		else $error("result appeared after a palette load");

	// no result word while the block waits for input with nothing pending
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_ready && !(in_valid && in_mode) |=> !out_valid)
		else $error("result appeared without a pixel");

endmodule

bind nearest_palette_color_quantizer npq_checker u_npq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in.valid),
	.in_ready        (in.ready),
	.in_mode         (in.mode),
	.out_valid       (out.valid),
	.out_ready       (out.ready),
	.out_color_index (out.color_index)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top : nearest palette colour quantizer testbench
// Loads palettes, streams RGBA pixels under several register settings and
// checks every colour index against an in-bench nearest-colour search.
// Both handshakes stall at random; one long result hold-off fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import npq_pkg::*;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} word_op_t;

	typedef struct packed {
		word_op_t        mode;
		logic [7:0]      entry_index;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pix_word_t;

	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned LONG_HOLD    = 400;

	// Own copy of palette and registers; predicts the index of each pixel word.
	class nearest_index_board;
		logic [3*CH_W-1:0] pal [PALETTE_ENTRIES];
		bit                written [PALETTE_ENTRIES];
		logic [REG_W-1:0]  entries_used;
		logic [IDX_W-1:0]  transp_idx;
		logic [CH_W-1:0]   cutoff;
		logic [IDX_W-1:0]  due_indices [$];
		int unsigned       errors, checked, loads, pixels, transparent;

		function new();
			entries_used = ENTRIES_RESET;
			transp_idx   = '0;
			cutoff       = CUTOFF_RESET;
			errors       = 0;
			checked      = 0;
			loads        = 0;
			pixels       = 0;
			transparent  = 0;
			foreach (written[i])
				written[i] = 1'b0;
		endfunction

		function int unsigned searched();
			return (entries_used > PALETTE_ENTRIES) ? PALETTE_ENTRIES : entries_used;
		endfunction

		// true when every entry that a search would read has been loaded
		function bit searchable();
			for (int unsigned i = 0; i < searched(); i++)
				if (!written[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void set_reg(npq_reg_t idx, logic [REG_W-1:0] v);
			case (idx)
				REG_ENTRIES_IN_USE:    entries_used = v;
				REG_TRANSPARENT_INDEX: transp_idx   = v[IDX_W-1:0];
				REG_ALPHA_CUTOFF:      cutoff       = v[CH_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_word(pix_word_t w);
			int unsigned      n, d, best_d;
			int               dr, dg, db;
			logic [IDX_W-1:0] best;
			if (w.mode == OP_LOAD) begin
				pal[w.entry_index]     = {w.red, w.green, w.blue};
				written[w.entry_index] = 1'b1;
				loads++;
				return;
			end
			pixels++;
			if (w.alpha <= cutoff) begin
				transparent++;
				due_indices.push_back(transp_idx);
				return;
			end
			n      = searched();
			best   = '0;
			best_d = 0;
			for (int unsigned j = 0; j < n; j++) begin
				dr = int'(pal[j][23:16]) - int'(w.red);
				dg = int'(pal[j][15:8])  - int'(w.green);
				db = int'(pal[j][7:0])   - int'(w.blue);
				d  = dr * dr + dg * dg + db * db;
				// strict less keeps the lowest index on a tie
				if (j == 0 || d < best_d) begin
					best_d = d;
					best   = j[IDX_W-1:0];
				end
			end
			due_indices.push_back(best);
		endfunction

		function void check_index(logic [IDX_W-1:0] got);
			logic [IDX_W-1:0] want;
			if (due_indices.size() == 0) begin
				errors++;
				$error("color_index: expected nothing, actual %0d", got);
				return;
			end
			want = due_indices.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$error("color_index: expected %0d, actual %0d", want, got);
			end
		endfunction

		function int unsigned pending();
			return due_indices.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_index;
	logic [REG_W-1:0]    cfg_data;

	npq_pix_if pix_if ();
	npq_idx_if idx_if ();

	nearest_index_board board;
	bit                 idle_off;
	bit                 hold_req;
	int unsigned        idle_pct;
	int unsigned        settings_done;

	nearest_palette_color_quantizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (pix_if),
		.out       (idx_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic pix_word_t mk_word(word_op_t op, logic [7:0] idx, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [7:0] a);
		pix_word_t w;
		w.mode        = op;
		w.entry_index = idx;
		w.red         = r;
		w.green       = g;
		w.blue        = b;
		w.alpha       = a;
		return w;
	endfunction

	// coarse levels give duplicate entries and distance ties
	function automatic logic [7:0] rand_shade();
		logic [7:0] s;
		case ($urandom_range(0, 3))
			0:       s = 8'd0;
			1:       s = 8'd255;
			2:       s = 8'($urandom_range(0, 3) * 85);
			default: s = 8'($urandom);
		endcase
		return s;
	endfunction

	task automatic push_word(input pix_word_t w);
		if (!idle_off && $urandom_range(0, 99) < idle_pct) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.mode        <= w.mode;
		pix_if.entry_index <= w.entry_index;
		pix_if.red         <= w.red;
		pix_if.green       <= w.green;
		pix_if.blue        <= w.blue;
		pix_if.alpha       <= w.alpha;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
		board.note_word(w);
	endtask

	task automatic drain_results();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// loads leave no result, so give the block time to finish the last word
	task automatic settle();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input npq_reg_t idx, input logic [REG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic configure(input logic [REG_W-1:0] used, input logic [7:0] tidx,
			input logic [7:0] cut);
		settle();
		write_reg(REG_ENTRIES_IN_USE, used);
		write_reg(REG_TRANSPARENT_INDEX, {1'b0, tidx});
		write_reg(REG_ALPHA_CUTOFF, {1'b0, cut});
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	task automatic run_phase(input int unsigned count, input bit long_hold, input bit pause);
		pix_word_t   w;
		int unsigned k, j, n, pick;
		for (k = 0; k < count; k++) begin
			idle_pct = ((k / 50) % 3 == 2) ? 0 : 15;
			if (k == count / 2) begin
				if (long_hold)
					hold_req = 1'b1;
				if (pause)
					drain_results();
			end
			n = board.searched();
			w = mk_word(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom));
			if ($urandom_range(0, 99) < 25) begin
				w.mode = OP_LOAD;
				if ($urandom_range(0, 1) && n > 0)
					w.entry_index = 8'($urandom_range(0, n - 1));
				w.red   = rand_shade();
				w.green = rand_shade();
				w.blue  = rand_shade();
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 4 && n > 0) begin
					j = $urandom_range(0, n - 1);
					{w.red, w.green, w.blue} = board.pal[j];
					if (pick == 0)
						w.green = w.green ^ 8'($urandom_range(0, 7));
				end else if (pick < 6) begin
					w.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					w.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					w.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end
				// opaque only when every searched entry holds a loaded colour
				if (board.cutoff == 8'd255 || !board.searchable() || $urandom_range(0, 3) == 0)
					w.alpha = 8'($urandom_range(0, board.cutoff));
				else
					w.alpha = 8'($urandom_range(board.cutoff + 1, 255));
			end
			push_word(w);
		end
	endtask

	// result side: random stalls, quiet stretches and one long hold-off
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned quiet_left;
		stall_left = 0;
		quiet_left = 0;
		idx_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idx_if.valid && idx_if.ready)
				board.check_index(idx_if.color_index);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !idle_off) begin
				if (quiet_left > 0)
					quiet_left--;
				else if ($urandom_range(0, 99) < 3)
					quiet_left = $urandom_range(40, 160);
				else if ($urandom_range(0, 99) < 20)
					stall_left = $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				idx_if.ready <= 1'b0;
				stall_left--;
			end else begin
				idx_if.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		board         = new();
		idle_off      = 1'b0;
		hold_req      = 1'b0;
		idle_pct      = 15;
		settings_done = 0;

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_ENTRIES_IN_USE;
		cfg_data           <= '0;
		pix_if.valid       <= 1'b0;
		pix_if.mode        <= OP_LOAD;
		pix_if.entry_index <= '0;
		pix_if.red         <= '0;
		pix_if.green       <= '0;
		pix_if.blue        <= '0;
		pix_if.alpha       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: nothing loaded yet, so transparent pixels only
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		push_word(mk_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128));

		configure(9'd4, 8'hA5, 8'd128);
		push_word(mk_word(OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		push_word(mk_word(OP_LOAD, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255));
		push_word(mk_word(OP_LOAD, 8'd2, 8'd255, 8'd0, 8'd0, 8'd0));
		push_word(mk_word(OP_LOAD, 8'd3, 8'd255, 8'd0, 8'd0, 8'd0));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd129));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd250, 8'd5, 8'd5, 8'd200));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd9, 8'd9, 8'd9, 8'd128));
		push_word(mk_word(OP_LOAD, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0));

		configure(9'd1, 8'd255, 8'd0);
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 8'd1));

		// no entries searched: opaque pixels map to index zero
		configure(9'd0, 8'd3, 8'd0);
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd77, 8'd1, 8'd200, 8'd255));
		push_word(mk_word(OP_PIXEL, 8'd0, 8'd77, 8'd1, 8'd200, 8'd0));

		// fill the whole palette so any entry count may be searched
		for (int unsigned e = 0; e < PALETTE_ENTRIES; e++)
			push_word(mk_word(OP_LOAD, 8'(e), rand_shade(), rand_shade(), rand_shade(),
				8'($urandom)));

		configure(9'd256, 8'd0, 8'd128);
		run_phase(80, 1'b0, 1'b0);
		configure(9'd16, 8'd200, 8'd64);
		run_phase(300, 1'b1, 1'b0);
		configure(9'd0, 8'd7, 8'd0);
		run_phase(150, 1'b0, 1'b0);
		configure(9'd511, 8'd85, 8'd254);
		run_phase(60, 1'b0, 1'b0);
		configure(9'd3, 8'd255, 8'd255);
		run_phase(150, 1'b0, 1'b0);
		configure(9'd257, 8'd1, 8'd100);
		run_phase(60, 1'b0, 1'b0);
		configure(9'($urandom_range(2, 64)), 8'($urandom_range(0, 255)),
			8'($urandom_range(1, 254)));
		run_phase(300, 1'b0, 1'b0);
		configure(9'd40, 8'd64, 8'd16);
		run_phase(300, 1'b0, 1'b1);
		idle_off = 1'b1;
		configure(9'd8, 8'd33, 8'd128);
		run_phase(300, 1'b0, 1'b0);

		settle();
		$display("Covered %0d palette loads and %0d pixels (%0d transparent) over %0d settings.",
			board.loads, board.pixels, board.transparent, settings_done);
		$display("Checked %0d colour indices, %0d mismatches.", board.checked, board.errors);
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
